// ===== hdl/ssb_pkg.sv =====
// Shared types and constants for the session slot balancer.
`default_nettype none
package ssb_pkg;

  localparam int unsigned SlotsDefault       = 32;
  localparam int unsigned DispatchersDefault = 16;

  // opcodes
  localparam logic [1:0] OP_NEW    = 2'd0;
  localparam logic [1:0] OP_ACK    = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_STATUS = 2'd3;

  // result kinds
  localparam logic [3:0] RK_ACCEPTED   = 4'd0;
  localparam logic [3:0] RK_TABLE_FULL = 4'd1;
  localparam logic [3:0] RK_FORWARDED  = 4'd2;
  localparam logic [3:0] RK_DEFERRED   = 4'd3;
  localparam logic [3:0] RK_CLOSED     = 4'd4;
  localparam logic [3:0] RK_NACK       = 4'd5;
  localparam logic [3:0] RK_STALE      = 4'd6;
  localparam logic [3:0] RK_TIMED_OUT  = 4'd7;
  localparam logic [3:0] RK_STATUS     = 4'd8;
  localparam logic [3:0] RK_TICK_DONE  = 4'd9;

  // configuration register indexes
  localparam logic [1:0] CFG_SLOTS   = 2'd0;
  localparam logic [1:0] CFG_DISP    = 2'd1;
  localparam logic [1:0] CFG_LIMIT   = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT = 2'd3;

  localparam logic [5:0]  SlotsInUseReset = 6'd32;
  localparam logic [4:0]  DispInUseReset  = 5'd16;
  localparam logic [15:0] DispLimitReset  = 16'hFFFF;
  localparam logic [31:0] TimeoutReset    = 32'd60;

  // control from the sequencer to the dispatcher table
  typedef struct packed {
    logic        start;     // begin a least-load scan
    logic        commit;    // charge the picked dispatcher
    logic        st_we;     // status write
    logic [3:0]  st_idx;
    logic [15:0] st_load;
    logic        st_ready;
  } disp_ctrl_t;

  // scan status back to the sequencer
  typedef struct packed {
    logic       busy;
    logic       found;
    logic [3:0] pick;
  } disp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/ssb_disp_table.sv =====
// Dispatcher load/ready table with a one-entry-per-cycle least-load scan.
`default_nettype none
module ssb_disp_table #(
  parameter int unsigned DISPATCHERS = ssb_pkg::DispatchersDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [4:0]         disp_in_use_i,
  input  wire logic [15:0]        disp_limit_i,
  input  wire ssb_pkg::disp_ctrl_t ctrl_i,
  output ssb_pkg::disp_stat_t     stat_o
);
  import ssb_pkg::*;

  localparam int unsigned DW  = (DISPATCHERS > 1) ? $clog2(DISPATCHERS) : 1;
  localparam int unsigned DCW = $clog2(DISPATCHERS + 1);

  logic [15:0]    load_q [DISPATCHERS];
  logic           rdy_q  [DISPATCHERS];
  logic           scan_q;
  logic [DCW-1:0] d_q;
  logic [15:0]    best_q;
  logic [DW-1:0]  pick_q;
  logic           fv_q;

  logic [31:0]    dlim32;
  logic [DCW-1:0] dlim;
  logic           hit;

  assign dlim32 = (32'(disp_in_use_i) > DISPATCHERS) ? DISPATCHERS : 32'(disp_in_use_i);
  assign dlim   = DCW'(dlim32);
  assign hit    = rdy_q[d_q[DW-1:0]] && (load_q[d_q[DW-1:0]] < best_q);

  // scan over the dispatchers in use
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= 1'b0;
      d_q    <= '0;
      best_q <= '0;
      pick_q <= '0;
      fv_q   <= 1'b0;
    end else if (ctrl_i.start) begin
      scan_q <= 1'b1;
      d_q    <= '0;
      best_q <= disp_limit_i;
      fv_q   <= 1'b0;
    end else if (scan_q) begin
      if (d_q < dlim) begin
        if (hit) begin
          best_q <= load_q[d_q[DW-1:0]];
          pick_q <= d_q[DW-1:0];
          fv_q   <= 1'b1;
        end
        d_q <= d_q + DCW'(1);
      end else begin
        scan_q <= 1'b0;
      end
    end
  end

  // status writes and load charging
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(DISPATCHERS); i++) begin
        load_q[i] <= '0;
        rdy_q[i]  <= 1'b1;
      end
    end else if (ctrl_i.st_we) begin
      if (32'(ctrl_i.st_idx) < DISPATCHERS) begin
        load_q[DW'(ctrl_i.st_idx)] <= ctrl_i.st_load;
        rdy_q[DW'(ctrl_i.st_idx)]  <= ctrl_i.st_ready;
      end
    end else if (ctrl_i.commit && fv_q) begin
      if (best_q != 16'hFFFF) begin
        load_q[pick_q] <= best_q + 16'd1;
      end
    end
  end

  assign stat_o.busy  = scan_q;
  assign stat_o.found = fv_q;
  assign stat_o.pick  = 4'(pick_q);

endmodule
`default_nettype wire

// ===== hdl/session_slot_balancer.sv =====
// Top level: slot table sequencer, slot memory and configuration registers.
//
// Usage: an item is accepted when start is high and busy is low.
// Results appear on the result ports for one cycle each, marked by
// result_valid_o, and cannot be held off; last_o marks the final
// result of an item. Configuration writes go over cfg_valid_i/cfg_ready_o
// (always ready) with cfg_index_i and cfg_data_i; the user must write
// them only while idle; the block itself does not enforce it.
// Timing: a status item gives its result in the cycle after acceptance
// and never raises busy. An ack reads the slot memory, then checks the
// entry. A new connection scans the slots one per cycle, then scans the
// dispatchers one per cycle. A tick scans the slots in use for expiry,
// reading the memory for each held slot, then again for retries, each
// retry costing a dispatcher scan. Sequence numbers and stamps sit in a
// synchronous memory with a registered read; the memory reads and the
// scans set the rate. Reset empties the table, zeroes loads and marks all
// dispatchers ready; no clearing pass is needed.
`default_nettype none
module session_slot_balancer #(
  parameter int unsigned SLOTS       = ssb_pkg::SlotsDefault,
  parameter int unsigned DISPATCHERS = ssb_pkg::DispatchersDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [31:0] now_time_i,
  input  wire logic [4:0]  slot_index_i,
  input  wire logic [31:0] ack_sequence_i,
  input  wire logic        ack_ok_i,
  input  wire logic [3:0]  dispatcher_index_i,
  input  wire logic [15:0] dispatcher_load_in_i,
  input  wire logic        dispatcher_ready_in_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             result_valid_o,
  output logic [3:0]       result_kind_o,
  output logic [4:0]       slot_o,
  output logic [3:0]       dispatcher_o,
  output logic [31:0]      sequence_res_o,
  output logic [5:0]       current_count_o,
  output logic [5:0]       highwater_o,
  output logic             last_o
);
  import ssb_pkg::*;

  localparam int unsigned SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SCW = $clog2(SLOTS + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_NC_SCAN  = 4'd1;
  localparam logic [3:0] S_NC_ACK   = 4'd2;
  localparam logic [3:0] S_FWD_SCAN = 4'd3;
  localparam logic [3:0] S_FWD_EMIT = 4'd4;
  localparam logic [3:0] S_ACK_CHK  = 4'd5;
  localparam logic [3:0] S_TO_SCAN  = 4'd6;
  localparam logic [3:0] S_TO_CHK   = 4'd7;
  localparam logic [3:0] S_RT_SCAN  = 4'd8;
  localparam logic [3:0] S_RT_SEQ   = 4'd9;

  // configuration
  logic [5:0]  slots_cfg_q;
  logic [4:0]  disp_cfg_q;
  logic [15:0] limit_cfg_q;
  logic [31:0] timeout_cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_cfg_q   <= SlotsInUseReset;
      disp_cfg_q    <= DispInUseReset;
      limit_cfg_q   <= DispLimitReset;
      timeout_cfg_q <= TimeoutReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SLOTS:   slots_cfg_q   <= cfg_data_i[5:0];
        CFG_DISP:    disp_cfg_q    <= cfg_data_i[4:0];
        CFG_LIMIT:   limit_cfg_q   <= cfg_data_i[15:0];
        CFG_TIMEOUT: timeout_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [31:0]    slim32;
  logic [SCW-1:0] slim;
  assign slim32 = (32'(slots_cfg_q) > SLOTS) ? SLOTS : 32'(slots_cfg_q);
  assign slim   = SCW'(slim32);

  // sequencer registers
  logic [3:0]     st_q, st_d;
  logic [1:0]     op_q, op_d;
  logic [31:0]    now_q, now_d;
  logic [31:0]    aseq_q, aseq_d;
  logic [4:0]     sidx_q, sidx_d;
  logic           aok_q, aok_d;
  logic [SCW-1:0] idx_q, idx_d;
  logic [SAW-1:0] found_q, found_d;
  logic           fv_q, fv_d;
  logic [SCW-1:0] cnt_q, cnt_d;
  logic [SCW-1:0] peak_q, peak_d;
  logic [31:0]    ctr_q, ctr_d;
  logic [31:0]    seq_q, seq_d;
  logic [SAW-1:0] cur_q, cur_d;

  // slot flags
  logic           used_q [SLOTS];
  logic           fwd_q  [SLOTS];
  logic           u_we, u_val, f_we, f_val;
  logic [SAW-1:0] flag_idx;

  // slot memory: {sequence, stamp}
  logic [63:0]    mem_q [SLOTS];
  logic [63:0]    rd_q;
  logic           m_we, m_re;
  logic [SAW-1:0] m_waddr, m_raddr;
  logic [63:0]    m_wdata;

  // result register
  logic        ov_q, ov_d, last_q, last_d;
  logic [3:0]  kind_q, kind_d, disp_q, disp_d;
  logic [4:0]  slot_q, slot_d;
  logic [31:0] rseq_q, rseq_d;
  logic [5:0]  cur_cnt_q, cur_cnt_d;

  disp_ctrl_t dctl;
  disp_stat_t dst;

  logic [SAW-1:0] scan_idx, ack_idx;
  logic           ack_in_range, stale, expired;

  assign scan_idx     = idx_q[SAW-1:0];
  assign ack_idx      = SAW'(sidx_q);
  assign ack_in_range = 32'(sidx_q) < SLOTS;
  assign stale        = !ack_in_range || !used_q[ack_idx] || (rd_q[63:32] != aseq_q);
  assign expired      = (now_q - rd_q[31:0]) > timeout_cfg_q;

  always_comb begin
    st_d = st_q; op_d = op_q; now_d = now_q; aseq_d = aseq_q; sidx_d = sidx_q;
    aok_d = aok_q; idx_d = idx_q; found_d = found_q; fv_d = fv_q; cnt_d = cnt_q;
    peak_d = peak_q; ctr_d = ctr_q; seq_d = seq_q; cur_d = cur_q;
    u_we = 1'b0; u_val = 1'b0; f_we = 1'b0; f_val = 1'b0; flag_idx = '0;
    m_we = 1'b0; m_re = 1'b0; m_waddr = '0; m_raddr = '0; m_wdata = '0;
    ov_d = 1'b0; last_d = 1'b0; kind_d = RK_ACCEPTED; disp_d = '0; slot_d = '0;
    rseq_d = '0; cur_cnt_d = '0;
    dctl = '0;

    unique case (st_q)
      S_IDLE: begin
        if (start) begin
          op_d = opcode_i; now_d = now_time_i; aseq_d = ack_sequence_i;
          sidx_d = slot_index_i; aok_d = ack_ok_i;
          idx_d = '0; fv_d = 1'b0; cnt_d = '0;
          unique case (opcode_i)
            OP_NEW: begin
              ctr_d = ctr_q + 32'd1;
              st_d  = S_NC_SCAN;
            end
            OP_ACK: begin
              m_re    = 1'b1;
              m_raddr = SAW'(slot_index_i);
              st_d    = S_ACK_CHK;
            end
            OP_TICK: st_d = S_TO_SCAN;
            OP_STATUS: begin
              dctl.st_we    = 1'b1;
              dctl.st_idx   = dispatcher_index_i;
              dctl.st_load  = dispatcher_load_in_i;
              dctl.st_ready = dispatcher_ready_in_i;
              ov_d = 1'b1; last_d = 1'b1; kind_d = RK_STATUS;
              disp_d = dispatcher_index_i;
            end
            default: ;
          endcase
        end
      end

      // first free slot and occupancy count
      S_NC_SCAN: begin
        if (idx_q < slim) begin
          if (!used_q[scan_idx]) begin
            if (!fv_q) begin
              found_d = scan_idx;
              fv_d    = 1'b1;
              cnt_d   = cnt_q + SCW'(1);
            end
          end else begin
            cnt_d = cnt_q + SCW'(1);
          end
          idx_d = idx_q + SCW'(1);
        end else if (!fv_q) begin
          ov_d = 1'b1; last_d = 1'b1; kind_d = RK_TABLE_FULL; rseq_d = ctr_q;
          st_d = S_IDLE;
        end else begin
          u_we = 1'b1; u_val = 1'b1; f_we = 1'b1; f_val = 1'b0; flag_idx = found_q;
          m_we = 1'b1; m_waddr = found_q; m_wdata = {ctr_q, now_q};
          if (cnt_q > peak_q) peak_d = cnt_q;
          st_d = S_NC_ACK;
        end
      end

      S_NC_ACK: begin
        ov_d = 1'b1; kind_d = RK_ACCEPTED; slot_d = 5'(found_q);
        rseq_d = ctr_q; cur_cnt_d = 6'(cnt_q);
        seq_d = ctr_q; cur_d = found_q;
        dctl.start = 1'b1;
        st_d = S_FWD_SCAN;
      end

      S_FWD_SCAN: begin
        if (!dst.busy) st_d = S_FWD_EMIT;
      end

      S_FWD_EMIT: begin
        dctl.commit = 1'b1;
        ov_d = 1'b1; slot_d = 5'(cur_q); rseq_d = seq_q;
        if (dst.found) begin
          kind_d = RK_FORWARDED; disp_d = dst.pick;
          f_we = 1'b1; f_val = 1'b1; flag_idx = cur_q;
        end else begin
          kind_d = RK_DEFERRED;
        end
        if (op_q == OP_NEW) begin
          last_d = 1'b1;
          st_d   = S_IDLE;
        end else begin
          idx_d = idx_q + SCW'(1);
          st_d  = S_RT_SCAN;
        end
      end

      S_ACK_CHK: begin
        ov_d = 1'b1; last_d = 1'b1; slot_d = sidx_q; rseq_d = aseq_q;
        flag_idx = ack_idx;
        if (stale) begin
          kind_d = RK_STALE;
        end else if (aok_q) begin
          kind_d = RK_CLOSED;
          u_we = 1'b1; f_we = 1'b1;
        end else begin
          kind_d = RK_NACK;
          f_we = 1'b1;
        end
        st_d = S_IDLE;
      end

      // expiry pass
      S_TO_SCAN: begin
        if (idx_q < slim) begin
          if (used_q[scan_idx]) begin
            m_re = 1'b1; m_raddr = scan_idx;
            st_d = S_TO_CHK;
          end else begin
            idx_d = idx_q + SCW'(1);
          end
        end else begin
          idx_d = '0;
          st_d  = S_RT_SCAN;
        end
      end

      S_TO_CHK: begin
        if (expired) begin
          ov_d = 1'b1; kind_d = RK_TIMED_OUT; slot_d = 5'(scan_idx);
          rseq_d = rd_q[63:32];
          u_we = 1'b1; f_we = 1'b1; flag_idx = scan_idx;
        end
        idx_d = idx_q + SCW'(1);
        st_d  = S_TO_SCAN;
      end

      // retry pass
      S_RT_SCAN: begin
        if (idx_q < slim) begin
          if (used_q[scan_idx] && !fwd_q[scan_idx]) begin
            m_re = 1'b1; m_raddr = scan_idx;
            st_d = S_RT_SEQ;
          end else begin
            idx_d = idx_q + SCW'(1);
          end
        end else begin
          ov_d = 1'b1; last_d = 1'b1; kind_d = RK_TICK_DONE;
          st_d = S_IDLE;
        end
      end

      S_RT_SEQ: begin
        seq_d = rd_q[63:32];
        cur_d = scan_idx;
        dctl.start = 1'b1;
        st_d = S_FWD_SCAN;
      end

      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ctr_q  <= '0;
      peak_q <= '0;
      ov_q   <= 1'b0;
      fv_q   <= 1'b0;
      idx_q  <= '0;
      cnt_q  <= '0;
      op_q   <= OP_NEW;
    end else begin
      st_q   <= st_d;
      ctr_q  <= ctr_d;
      peak_q <= peak_d;
      ov_q   <= ov_d;
      fv_q   <= fv_d;
      idx_q  <= idx_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    now_q <= now_d; aseq_q <= aseq_d; sidx_q <= sidx_d; aok_q <= aok_d;
    found_q <= found_d; seq_q <= seq_d; cur_q <= cur_d;
    last_q <= last_d; kind_q <= kind_d; disp_q <= disp_d; slot_q <= slot_d;
    rseq_q <= rseq_d; cur_cnt_q <= cur_cnt_d;
  end

  // slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(SLOTS); i++) begin
        used_q[i] <= 1'b0;
        fwd_q[i]  <= 1'b0;
      end
    end else begin
      if (u_we) used_q[flag_idx] <= u_val;
      if (f_we) fwd_q[flag_idx]  <= f_val;
    end
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (m_we) mem_q[m_waddr] <= m_wdata;
    if (m_re) rd_q <= mem_q[m_raddr];
  end

  ssb_disp_table #(
    .DISPATCHERS(DISPATCHERS)
  ) u_disp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .disp_in_use_i(disp_cfg_q),
    .disp_limit_i (limit_cfg_q),
    .ctrl_i       (dctl),
    .stat_o       (dst)
  );

  assign busy            = (st_q != S_IDLE);
  assign result_valid_o  = ov_q;
  assign result_kind_o   = kind_q;
  assign slot_o          = slot_q;
  assign dispatcher_o    = disp_q;
  assign sequence_res_o  = rseq_q;
  assign current_count_o = cur_cnt_q;
  assign highwater_o     = 6'(peak_q);
  assign last_o          = last_q;

  // non-status items raise busy in the cycle after they are accepted
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i != OP_STATUS) |=> busy)
    else $error("busy not raised after accepted item");

  // the final result of an item is shown only once the sequencer is idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy)
    else $error("final result while still busy");

  // high-water mark never exceeds the table
  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(peak_q) <= SLOTS)
    else $error("high-water mark beyond table size");

endmodule
`default_nettype wire
